### design/uts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_pkg
// types and constants shared by the text sanitizer modules
// ----------------------------------------------------------------------------
package uts_pkg;

    localparam int COUNT_BITS = 10;
    localparam int LIMIT_BITS = 10;
    localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam int MAX_OUT    = 5;
    localparam int NUM_BITS   = 3;
    localparam int HOLD_DEPTH = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = 2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(640);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

    localparam logic [7:0] QMARK    = 8'h3f;
    localparam logic [7:0] SPACE    = 8'h20;
    localparam logic [7:0] NEWLINE  = 8'h0a;
    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;
    localparam logic [7:0] LEAD_E0  = 8'he0;
    localparam logic [7:0] LEAD_ED  = 8'hed;
    localparam logic [7:0] LEAD_F0  = 8'hf0;
    localparam logic [7:0] LEAD_F4  = 8'hf4;
    localparam logic [7:0] MIN_E0   = 8'ha0;
    localparam logic [7:0] MAX_ED   = 8'h9f;
    localparam logic [7:0] MIN_F0   = 8'h90;
    localparam logic [7:0] MAX_F4   = 8'h8f;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_text;
    } out_item_t;

    typedef struct packed {
        logic [NUM_BITS-1:0]    num;
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [MAX_OUT-1:0]     eot;
    } job_t;

endpackage

### design/uts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_front
// accepts input bytes, tracks the utf-8 sequence and limit, builds result jobs
// ----------------------------------------------------------------------------
module uts_front
    import uts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [LIMIT_BITS-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    input  logic                  q_full,
    output logic                  q_push,
    output job_t                  q_job
);

    logic [LIMIT_BITS-1:0] limit_reg;
    logic [1:0]            held_count_reg, held_count_next;
    logic [2:0]            exp_len_reg, exp_len_next;
    logic [COUNT_BITS-1:0] consumed_reg, consumed_next;
    logic                  lim_hit_reg, lim_hit_next;
    logic [HOLD_DEPTH-1:0][7:0] held_reg, held_next;
    logic                  accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [7:0]          b;
        logic [NUM_BITS-1:0] n;
        logic                ok;
        logic                do_start;
        logic [2:0]          len;

        b               = in_item.data_byte;
        n               = '0;
        ok              = 1'b0;
        do_start        = 1'b0;
        len             = 3'd0;
        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        consumed_next   = consumed_reg;
        lim_hit_next    = lim_hit_reg;
        held_next       = held_reg;
        q_job           = '0;

        // limit check before the byte
        if (!lim_hit_next && (CMP_BITS'(consumed_next) >= CMP_BITS'(limit_reg)))
        begin
            lim_hit_next = 1'b1;
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                if (2'(i) < held_count_next)
                begin
                    q_job.bytes[n] = QMARK;
                    n = n + 1'b1;
                end
            end
            held_count_next = '0;
            exp_len_next    = '0;
        end

        if (!lim_hit_next)
        begin
            if (held_count_next == 2'd0)
            begin
                do_start = 1'b1;
            end
            else
            begin
                ok = (b[7:6] == 2'b10);
                if (ok && held_count_next == 2'd1)
                begin
                    if (held_next[0] == LEAD_E0 && b < MIN_E0) ok = 1'b0;
                    if (held_next[0] == LEAD_ED && b > MAX_ED) ok = 1'b0;
                    if (held_next[0] == LEAD_F0 && b < MIN_F0) ok = 1'b0;
                    if (held_next[0] == LEAD_F4 && b > MAX_F4) ok = 1'b0;
                end
                if (!ok)
                begin
                    for (int i = 0; i < HOLD_DEPTH; i++)
                    begin
                        if (2'(i) < held_count_next)
                        begin
                            q_job.bytes[n] = QMARK;
                            n = n + 1'b1;
                        end
                    end
                    held_count_next = '0;
                    exp_len_next    = '0;
                    do_start        = 1'b1;
                end
                else if (({1'b0, held_count_next} + 3'd1) >= exp_len_next)
                begin
                    for (int i = 0; i < HOLD_DEPTH; i++)
                    begin
                        if (2'(i) < held_count_next)
                        begin
                            q_job.bytes[n] = held_next[i];
                            n = n + 1'b1;
                        end
                    end
                    q_job.bytes[n] = b;
                    n = n + 1'b1;
                    held_count_next = '0;
                    exp_len_next    = '0;
                end
                else
                begin
                    held_next[held_count_next] = b;
                    held_count_next = held_count_next + 2'd1;
                end
            end

            if (do_start)
            begin
                if (!b[7])
                begin
                    q_job.bytes[n] = (b < SPACE && b != NEWLINE) ? SPACE : b;
                    n = n + 1'b1;
                end
                else
                begin
                    if (b >= LEAD2_LO && b <= LEAD2_HI)
                        len = 3'd2;
                    else if (b >= LEAD3_LO && b <= LEAD3_HI)
                        len = 3'd3;
                    else if (b >= LEAD4_LO && b <= LEAD4_HI)
                        len = 3'd4;
                    if (len == 3'd0)
                    begin
                        q_job.bytes[n] = QMARK;
                        n = n + 1'b1;
                    end
                    else
                    begin
                        held_next[0]    = b;
                        held_count_next = 2'd1;
                        exp_len_next    = len;
                    end
                end
            end

            if (consumed_next != COUNT_MAX)
                consumed_next = consumed_next + 1'b1;

            // limit check after the byte
            if (CMP_BITS'(consumed_next) >= CMP_BITS'(limit_reg))
            begin
                lim_hit_next = 1'b1;
                for (int i = 0; i < HOLD_DEPTH; i++)
                begin
                    if (2'(i) < held_count_next)
                    begin
                        q_job.bytes[n] = QMARK;
                        n = n + 1'b1;
                    end
                end
                held_count_next = '0;
                exp_len_next    = '0;
            end
        end

        if (in_item.last)
        begin
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                if (2'(i) < held_count_next)
                begin
                    q_job.bytes[n] = QMARK;
                    n = n + 1'b1;
                end
            end
            held_count_next = '0;
            exp_len_next    = '0;
            q_job.bytes[n]  = 8'h00;
            q_job.eot[n]    = 1'b1;
            n = n + 1'b1;
            consumed_next   = '0;
            lim_hit_next    = 1'b0;
        end

        q_job.num = n;
    end

    assign q_push = accept && (q_job.num != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_RESET;
            held_count_reg <= '0;
            exp_len_reg    <= '0;
            consumed_reg   <= '0;
            lim_hit_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (accept)
            begin
                held_count_reg <= held_count_next;
                exp_len_reg    <= exp_len_next;
                consumed_reg   <= consumed_next;
                lim_hit_reg    <= lim_hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule

### design/uts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module uts_queue
    import uts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_job
);

    job_t                 slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic                 do_push, do_pop;

    assign full      = (count_reg == (QPTR_BITS+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### design/uts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_back
// unpacks queued jobs into one output item per cycle while out_ready is high
// ----------------------------------------------------------------------------
module uts_back
    import uts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_not_empty,
    input  job_t      q_job,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    job_t                cur_reg;
    logic                cur_valid_reg;
    logic [NUM_BITS-1:0] pos_reg;
    logic                done;

    assign done      = out_ready && (pos_reg == cur_reg.num - 1'b1);
    assign q_pop     = q_not_empty && (!cur_valid_reg || done);
    assign out_valid = cur_valid_reg;

    always_comb
    begin
        out_item.out_byte    = cur_reg.bytes[pos_reg];
        out_item.end_of_text = cur_reg.eot[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (cur_valid_reg && done)
            begin
                cur_valid_reg <= 1'b0;
                pos_reg       <= '0;
            end
            else if (cur_valid_reg && out_ready)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_job;
    end

endmodule

### design/utf8_text_sanitizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_sanitizer
// utf-8 check with '?' replacement, control byte cleanup and byte limit
//
// input channel in_valid/in_ready/in_item carries one source byte per item,
// with last set on the final byte of a string. output channel
// out_valid/out_ready/out_item carries sanitized bytes, then one terminator
// item (byte 0, end_of_text set) after each string.
// cfg_wr_en/cfg_wr_data write byte_limit (reset 640); the user must write it
// only while idle; the block does not enforce this. the front takes
// one byte per cycle while the queue is not full and turns it into a job of 0
// to 5 output items; a 4-entry job queue feeds the back, which sends one item
// per cycle while out_ready is high. a job is registered in the queue, then
// in the back's current-job register, before out_valid rises. throughput is
// one input per cycle while outputs keep pace; jobs of several items (a
// 4-byte sequence gives 4 items at once) drain slower than they arrive, fill
// the queue, and then in_ready drops until the back frees an entry.
// if out_ready stays low, the queue fills and the input stalls; no item is
// lost. reset clears the sequence state, counts, queue and output stage.
// ----------------------------------------------------------------------------
module utf8_text_sanitizer
    import uts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [LIMIT_BITS-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item
);

    logic q_full, q_push, q_pop, q_not_empty;
    job_t push_job, pop_job;

    uts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    uts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    uts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

### dv/utf8_text_sanitizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_sanitizer_test
// self-checking test of the utf-8 text sanitizer
//
// drives source strings one byte per item and predicts the sanitized output
// with a local model of the sequence, limit and terminator rules. directed
// strings cover control bytes, every lead range, overlong and surrogate
// rejection, truncated sequences and the byte limit; random strings mix
// well-formed text with noise and broken sequences under several limits,
// with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module utf8_text_sanitizer_test;
    import uts_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 250;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [LIMIT_BITS-1:0] cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;

    // model state
    logic [7:0]            held_seq [HOLD_DEPTH];
    logic [2:0]            seq_len = '0;
    logic [1:0]            held_n = '0;
    logic [COUNT_BITS-1:0] scanned_count = '0;
    logic                  limit_hit = 1'b0;
    logic [LIMIT_BITS-1:0] byte_limit = LIMIT_RESET;

    out_item_t             expected_text [$];
    out_item_t             head_item;
    int                    errors = 0;
    int                    sent_items = 0;
    int                    idle_cycles = 0;
    int                    burst_left = 0;
    bit                    gaps_on = 1'b1;
    int                    stall_mode = 0;
    int                    ready_run = 0;
    bit                    ready_level = 1'b1;

    utf8_text_sanitizer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void queue_out(logic [7:0] b, logic eot);
        out_item_t it;
        it.out_byte    = b;
        it.end_of_text = eot;
        expected_text.push_back(it);
    endfunction

    function automatic void release_held();
        for (int i = 0; i < int'(held_n); i++)
            queue_out(QMARK, 1'b0);
        held_n  = '0;
        seq_len = '0;
    endfunction

    function automatic void start_seq(logic [7:0] b);
        if (b < 8'h80)
            queue_out((b < SPACE && b != NEWLINE) ? SPACE : b, 1'b0);
        else
        begin
            if (b >= LEAD2_LO && b <= LEAD2_HI)
                seq_len = 3'd2;
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
                seq_len = 3'd3;
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
                seq_len = 3'd4;
            else
                seq_len = 3'd0;
            if (seq_len == 0)
                queue_out(QMARK, 1'b0);
            else
            begin
                held_seq[0] = b;
                held_n      = 2'd1;
            end
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        bit ok;
        ok = (b[7:6] == 2'b10);
        if (ok && held_n == 1)
        begin
            if (held_seq[0] == LEAD_E0 && b < MIN_E0) ok = 1'b0;
            if (held_seq[0] == LEAD_ED && b > MAX_ED) ok = 1'b0;
            if (held_seq[0] == LEAD_F0 && b < MIN_F0) ok = 1'b0;
            if (held_seq[0] == LEAD_F4 && b > MAX_F4) ok = 1'b0;
        end
        if (held_n == 0)
            start_seq(b);
        else if (!ok)
        begin
            release_held();
            start_seq(b);
        end
        else if (int'(held_n) + 1 >= int'(seq_len))
        begin
            for (int i = 0; i < int'(held_n); i++)
                queue_out(held_seq[i], 1'b0);
            queue_out(b, 1'b0);
            held_n  = '0;
            seq_len = '0;
        end
        else
        begin
            held_seq[held_n] = b;
            held_n           = held_n + 2'd1;
        end
    endfunction

    function automatic void apply_limit();
        if (!limit_hit && CMP_BITS'(scanned_count) >= CMP_BITS'(byte_limit))
        begin
            limit_hit = 1'b1;
            release_held();
        end
    endfunction

    function automatic void predict_sanitized(in_item_t it);
        apply_limit();
        if (!limit_hit)
        begin
            take_byte(it.data_byte);
            if (scanned_count != COUNT_MAX)
                scanned_count = scanned_count + 1'b1;
            apply_limit();
        end
        if (it.last)
        begin
            release_held();
            queue_out(8'h00, 1'b1);
            scanned_count = '0;
            limit_hit     = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int       gap;
        in_item_t it;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
                gap = $urandom_range(0, 6);
        end
        burst_left--;
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        it.data_byte = b;
        it.last      = is_last;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_sanitized(it);
        sent_items++;
    endtask

    task automatic send_string(input logic [7:0] bytes [$]);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic drain_wait();
        @(negedge clk) in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_BITS-1:0] value);
        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        byte_limit = value;
        @(negedge clk) cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick(int lo, int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // random text of n_tokens characters, noise bytes and broken sequences
    task automatic send_text(input int n_tokens);
        logic [7:0] bytes [$];
        logic [7:0] lead;
        int         r;
        for (int t = 0; t < n_tokens; t++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                bytes.push_back(pick(8'h00, 8'h7f));
            else if (r < 50)
            begin
                bytes.push_back(pick(LEAD2_LO, LEAD2_HI));
                bytes.push_back(pick(8'h80, 8'hbf));
            end
            else if (r < 62)
            begin
                lead = pick(LEAD3_LO, LEAD3_HI);
                bytes.push_back(lead);
                if (lead == LEAD_E0)
                    bytes.push_back(pick(MIN_E0, 8'hbf));
                else if (lead == LEAD_ED)
                    bytes.push_back(pick(8'h80, MAX_ED));
                else
                    bytes.push_back(pick(8'h80, 8'hbf));
                bytes.push_back(pick(8'h80, 8'hbf));
            end
            else if (r < 72)
            begin
                lead = pick(LEAD4_LO, LEAD4_HI);
                bytes.push_back(lead);
                if (lead == LEAD_F0)
                    bytes.push_back(pick(MIN_F0, 8'hbf));
                else if (lead == LEAD_F4)
                    bytes.push_back(pick(8'h80, MAX_F4));
                else
                    bytes.push_back(pick(8'h80, 8'hbf));
                bytes.push_back(pick(8'h80, 8'hbf));
                bytes.push_back(pick(8'h80, 8'hbf));
            end
            else if (r < 82)
                bytes.push_back(pick(8'h00, 8'hff));
            else if (r < 92)
            begin
                // lead cut short by whatever follows
                bytes.push_back(pick(LEAD3_LO, LEAD4_HI));
                if ($urandom_range(0, 1))
                    bytes.push_back(pick(8'h80, 8'hbf));
            end
            else
            begin
                // out-of-range second byte
                case ($urandom_range(0, 3))
                    0:
                    begin
                        bytes.push_back(LEAD_E0);
                        bytes.push_back(pick(8'h80, MAX_ED));
                    end
                    1:
                    begin
                        bytes.push_back(LEAD_ED);
                        bytes.push_back(pick(MIN_E0, 8'hbf));
                    end
                    2:
                    begin
                        bytes.push_back(LEAD_F0);
                        bytes.push_back(pick(8'h80, MAX_F4));
                    end
                    default:
                    begin
                        bytes.push_back(LEAD_F4);
                        bytes.push_back(pick(MIN_F0, 8'hbf));
                    end
                endcase
            end
        end
        for (int i = 0; i < bytes.size(); i++)
        begin
            if ($urandom_range(0, 39) == 0)
                drain_wait();
            send_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic test_ascii_controls();
        stall_mode = 1;
        send_string('{8'h00, NEWLINE, 8'h1f, SPACE, 8'h7f, 8'h41});
    endtask

    task automatic test_sequences_and_errors();
        stall_mode = 2;
        send_string('{8'hc2, 8'h80, LEAD_F4, MAX_F4, 8'hbf, 8'hbf,
                      LEAD_E0, MAX_ED, LEAD_ED, MIN_E0, 8'hf5, 8'hff, 8'hc1,
                      LEAD_F0, MIN_F0, 8'h80});
    endtask

    task automatic test_zero_limit();
        set_limit('0);
        send_string('{8'h41, LEAD2_HI});
    endtask

    task automatic test_limit_cut();
        set_limit(LIMIT_BITS'(2));
        send_string('{8'he2, 8'h82, 8'hac});
    endtask

    task automatic test_limit_lowered();
        set_limit(LIMIT_RESET);
        send_byte(8'h41, 1'b0);
        send_byte(LEAD_F0, 1'b0);
        send_byte(8'h9f, 1'b0);
        set_limit(LIMIT_BITS'(1));
        send_byte(8'h98, 1'b1);
    endtask

    task automatic test_random_text();
        int phase;
        logic [LIMIT_BITS-1:0] lim;
        phase = 0;
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS && phase < 80)
        begin
            case (phase % 8)
                0: lim = '1;
                1: lim = LIMIT_RESET;
                2: lim = '0;
                3: lim = LIMIT_BITS'(1);
                4: lim = LIMIT_BITS'(2);
                5: lim = LIMIT_BITS'($urandom_range(3, 8));
                6: lim = LIMIT_BITS'($urandom_range(9, 40));
                default: lim = LIMIT_BITS'($urandom_range(0, 1023));
            endcase
            set_limit(lim);
            stall_mode = phase % 3;
            gaps_on    = (phase % 4) != 3;
            repeat ($urandom_range(3, 7)) send_text($urandom_range(1, 10));
            phase++;
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (ready_run > 0)
            ready_run--;
        else
        begin
            case (stall_mode)
                0: ready_level = 1'b1;
                1: ready_level = $urandom_range(0, 3) != 0;
                default:
                begin
                    ready_level = !ready_level;
                    ready_run   = ready_level ? $urandom_range(0, 8) : $urandom_range(0, 24);
                end
            endcase
            out_ready <= ready_level;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected item: out_byte %h end_of_text %b",
                       out_item.out_byte, out_item.end_of_text);
                errors++;
            end
            else
            begin
                head_item = expected_text.pop_front();
                if (out_item.out_byte !== head_item.out_byte)
                begin
                    $error("out_byte expected %h actual %h",
                           head_item.out_byte, out_item.out_byte);
                    errors++;
                end
                if (out_item.end_of_text !== head_item.end_of_text)
                begin
                    $error("end_of_text expected %b actual %b",
                           head_item.end_of_text, out_item.end_of_text);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL utf8_text_sanitizer");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_ascii_controls();
        test_sequences_and_errors();
        test_zero_limit();
        test_limit_cut();
        test_limit_lowered();
        test_random_text();

        drain_wait();
        repeat (20) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            $error("%0d expected items never arrived", expected_text.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS utf8_text_sanitizer");
        else
            $display("FAIL utf8_text_sanitizer");
        $finish;
    end

endmodule

### sim.f
design/uts_pkg.sv
design/uts_front.sv
design/uts_queue.sv
design/uts_back.sv
design/utf8_text_sanitizer.sv
dv/utf8_text_sanitizer_test.sv
